FILE: rtl/jset_pkg.sv
// ----------------------------------------------------------------------------
// jset_pkg
// Shared widths, register indexes, reset values and types for the Julia-set
// escape-time pixel evaluator.
// ----------------------------------------------------------------------------
package jset_pkg;

    localparam int WORD_W    = 32;
    localparam int PROD_W    = 64;
    localparam int DEN_W     = 13;
    localparam int PIXEL_W   = 12;
    localparam int COUNT_W   = 12;
    localparam int COLOUR_W  = 24;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int FRAC_BITS_DEFAULT  = 28;

    // Colour scaling: green = count * 255 / max_iter, blue is a fixed level.
    localparam int         GREEN_SHIFT = 8;
    localparam logic [7:0] BLUE_LEVEL  = 8'd128;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_C_REAL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER     = 3'd4;

    localparam logic [DEN_W-1:0]   RESET_IMAGE_WIDTH  = 13'd640;
    localparam logic [DEN_W-1:0]   RESET_IMAGE_HEIGHT = 13'd480;
    localparam logic [WORD_W-1:0]  RESET_C_REAL       = 32'd0;
    localparam logic [WORD_W-1:0]  RESET_C_IMAG       = 32'd0;
    localparam logic [COUNT_W-1:0] RESET_MAX_ITER     = 12'd255;

    typedef struct packed {
        logic [DEN_W-1:0]         image_width;
        logic [DEN_W-1:0]         image_height;
        logic signed [WORD_W-1:0] c_real;
        logic signed [WORD_W-1:0] c_imag;
        logic [COUNT_W-1:0]       max_iter;
    } jset_cfg_t;

endpackage

FILE: rtl/jset_cfg.sv
// ----------------------------------------------------------------------------
// jset_cfg
// Configuration register file written through a valid/ready channel.
// ----------------------------------------------------------------------------
module jset_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [jset_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jset_pkg::WORD_W-1:0]    cfg_data,
    output jset_pkg::jset_cfg_t            cfg
);
    import jset_pkg::*;

    jset_cfg_t cfg_reg;
    jset_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data[DEN_W-1:0];
                CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data[DEN_W-1:0];
                CFG_C_REAL:       cfg_next.c_real       = cfg_data;
                CFG_C_IMAG:       cfg_next.c_imag       = cfg_data;
                CFG_MAX_ITER:     cfg_next.max_iter     = cfg_data[COUNT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= RESET_IMAGE_WIDTH;
            cfg_reg.image_height <= RESET_IMAGE_HEIGHT;
            cfg_reg.c_real       <= RESET_C_REAL;
            cfg_reg.c_imag       <= RESET_C_IMAG;
            cfg_reg.max_iter     <= RESET_MAX_ITER;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/jset_div.sv
// ----------------------------------------------------------------------------
// jset_div
// Bit-serial restoring divider. Divides num * 2^(steps - NUM_W) by den,
// one quotient bit per cycle, and keeps the low 32 quotient bits.
// ----------------------------------------------------------------------------
module jset_div
#(
    parameter int NUM_W  = 20,
    parameter int STEP_W = 7
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [NUM_W-1:0]             num,
    input  logic [jset_pkg::DEN_W-1:0]   den,
    input  logic [STEP_W-1:0]            steps,
    output logic                         done,
    output logic [jset_pkg::WORD_W-1:0]  quot
);
    import jset_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [WORD_W-1:0]  quot_reg, quot_next;
    logic [DEN_W:0]     rem_shift;
    logic [DEN_W:0]     rem_diff;
    logic               q_bit;

    // Numerator bits leave MSB first; zeros follow for the fraction steps.
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign q_bit     = (rem_shift >= {1'b0, den_reg});

    assign done = done_reg;
    assign quot = quot_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = steps;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            rem_next  = q_bit ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quot_next = {quot_reg[WORD_W-2:0], q_bit};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

endmodule

FILE: rtl/julia_set_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// julia_set_escape_time_pixel
// Escape-time evaluator for one pixel of a Julia set in signed fixed point.
// ----------------------------------------------------------------------------
// One pixel is in work at a time; s_axis_tready is high only while the block
// is idle. A pixel first maps x and y to the start point through the
// bit-serial divider, then runs the iterations of z = z^2 + c, in which the
// single 32x32 multiplier forms zx*zx, zy*zy and zx*zy one after another and
// a further state writes the new z. An escaping pixel then goes through its
// last magnitude test and the colour division. The result sits in an output
// register, so the next pixel is accepted while it waits to be taken.
module julia_set_escape_time_pixel
#(
    parameter int COORD_BITS = jset_pkg::COORD_BITS_DEFAULT,
    parameter int FRAC_BITS  = jset_pkg::FRAC_BITS_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [jset_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jset_pkg::WORD_W-1:0]     cfg_data,
    // Pixel in: [11:0] pixel_x, [23:12] pixel_y.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [jset_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // Result out: [23:0] colour, [35:24] iteration_count, [36] inside_set,
    // [39:37] zero.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [jset_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import jset_pkg::*;

    localparam int PX_W   = (COORD_BITS < PIXEL_W) ? COORD_BITS : PIXEL_W;
    localparam int NUM_W  = (PX_W + 2 > 20) ? PX_W + 2 : 20;
    localparam int STEP_W = $clog2(NUM_W + FRAC_BITS + 1);
    localparam logic [STEP_W-1:0] MAP_STEPS = STEP_W'(NUM_W + FRAC_BITS);
    localparam logic [STEP_W-1:0] COL_STEPS = STEP_W'(NUM_W);
    localparam logic [PROD_W-1:0] OFF_X = PROD_W'(3) << (FRAC_BITS - 1);
    localparam logic [PROD_W-1:0] OFF_Y = PROD_W'(1) << FRAC_BITS;
    localparam int  BOUND_SHIFT = 2 * FRAC_BITS + 2;
    localparam bit  HAVE_BOUND  = (BOUND_SHIFT < PROD_W);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIVX = 4'd1;
    localparam logic [3:0] S_DIVY = 4'd2;
    localparam logic [3:0] S_XX   = 4'd3;
    localparam logic [3:0] S_YY   = 4'd4;
    localparam logic [3:0] S_XY   = 4'd5;
    localparam logic [3:0] S_UPD  = 4'd6;
    localparam logic [3:0] S_COL  = 4'd7;
    localparam logic [3:0] S_DIVC = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    jset_cfg_t cfg;

    logic [3:0]                state_reg, state_next;
    logic [COUNT_W-1:0]        cnt_reg, cnt_next;
    logic                      m_valid_reg, m_valid_next;
    logic [PX_W-1:0]           py_reg;
    logic signed [WORD_W-1:0]  zx_reg, zy_reg;
    logic signed [PROD_W-1:0]  xx_reg, yy_reg, xy_reg, diff_reg;
    logic [7:0]                green_reg;
    logic [OUT_DATA_W-1:0]     out_reg;

    logic                      accept;
    logic                      limit_hit;
    logic                      escape;
    logic [PROD_W-1:0]         mag;
    logic signed [WORD_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  x_shift, y_shift;
    logic [PX_W-1:0]           px_in;
    logic [NUM_W-1:0]          px_ext, py_ext, col_num;
    logic [19:0]               cnt_scaled;
    logic [DEN_W-1:0]          width_eff, height_eff;

    logic                      div_start;
    logic [NUM_W-1:0]          div_num;
    logic [DEN_W-1:0]          div_den;
    logic [STEP_W-1:0]         div_steps;
    logic                      div_done;
    logic [WORD_W-1:0]         div_quot;

    jset_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    jset_div
    #(
        .NUM_W  (NUM_W),
        .STEP_W (STEP_W)
    )
    u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .steps (div_steps),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_reg;

    assign px_in      = s_axis_tdata[PX_W-1:0];
    assign px_ext     = NUM_W'(px_in);
    assign py_ext     = NUM_W'(py_reg);
    assign cnt_scaled = (20'(cnt_reg) << GREEN_SHIFT) - 20'(cnt_reg);
    assign col_num    = NUM_W'(cnt_scaled);
    assign width_eff  = (cfg.image_width == '0) ? DEN_W'(1) : cfg.image_width;
    assign height_eff = (cfg.image_height == '0) ? DEN_W'(1) : cfg.image_height;

    assign limit_hit = (cnt_reg == cfg.max_iter);

    // Escape test on the exact squared magnitude; both squares are
    // non-negative and at most 2^62, so the sum cannot wrap.
    assign mag    = xx_reg + yy_reg;
    assign escape = HAVE_BOUND && ((mag >> BOUND_SHIFT) != '0);

    assign mul_p   = mul_a * mul_b;
    assign x_shift = diff_reg >>> FRAC_BITS;
    assign y_shift = xy_reg >>> (FRAC_BITS - 1);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            S_YY:
            begin
                mul_a = zy_reg;
                mul_b = zy_reg;
            end
            S_XY:
            begin
                mul_a = zx_reg;
                mul_b = zy_reg;
            end
            default:
            begin
                mul_a = zx_reg;
                mul_b = zx_reg;
            end
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = col_num;
        div_den   = DEN_W'(cfg.max_iter);
        div_steps = COL_STEPS;
        case (state_reg)
            S_IDLE:
            begin
                div_start = accept;
                div_num   = (px_ext << 1) + px_ext;
                div_den   = width_eff;
                div_steps = MAP_STEPS;
            end
            S_DIVX:
            begin
                div_start = div_done;
                div_num   = py_ext << 1;
                div_den   = height_eff;
                div_steps = MAP_STEPS;
            end
            S_COL:
            begin
                div_start = !limit_hit;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DIVX;
                end
            end
            S_DIVX:
            begin
                if (div_done)
                begin
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_done)
                begin
                    cnt_next   = '0;
                    state_next = S_XX;
                end
            end
            S_XX:
            begin
                state_next = limit_hit ? S_COL : S_YY;
            end
            S_YY:
            begin
                state_next = S_XY;
            end
            S_XY:
            begin
                state_next = escape ? S_COL : S_UPD;
            end
            S_UPD:
            begin
                cnt_next   = cnt_reg + COUNT_W'(1);
                state_next = S_XX;
            end
            S_COL:
            begin
                state_next = limit_hit ? S_OUT : S_DIVC;
            end
            S_DIVC:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            py_reg <= s_axis_tdata[PIXEL_W +: PX_W];
        end
        if ((state_reg == S_DIVX) && div_done)
        begin
            zx_reg <= div_quot - OFF_X[WORD_W-1:0];
        end
        if ((state_reg == S_DIVY) && div_done)
        begin
            zy_reg <= div_quot - OFF_Y[WORD_W-1:0];
        end
        if (state_reg == S_XX)
        begin
            xx_reg <= mul_p;
        end
        if (state_reg == S_YY)
        begin
            yy_reg <= mul_p;
        end
        if (state_reg == S_XY)
        begin
            xy_reg   <= mul_p;
            diff_reg <= xx_reg - yy_reg;
        end
        if (state_reg == S_UPD)
        begin
            zx_reg <= x_shift[WORD_W-1:0] + cfg.c_real;
            zy_reg <= y_shift[WORD_W-1:0] + cfg.c_imag;
        end
        if ((state_reg == S_DIVC) && div_done)
        begin
            green_reg <= div_quot[7:0];
        end
        if ((state_reg == S_OUT) && (!m_valid_reg || m_axis_tready))
        begin
            out_reg <= {3'b000, limit_hit, cnt_reg,
                        limit_hit ? COLOUR_W'(0) : {8'h00, green_reg, BLUE_LEVEL}};
        end
    end

endmodule

FILE: tb/julia_set_escape_time_pixel_tb.sv
// ----------------------------------------------------------------------------
// julia_set_escape_time_pixel_tb
// Drives pixel coordinates into the Julia-set evaluator under a series of
// frame sizes, Julia constants and iteration limits. Each pixel's count,
// inside flag and colour are predicted in Q4.28 fixed point and checked
// beat by beat against the result stream, with random gaps and stalls.
// ----------------------------------------------------------------------------
module julia_set_escape_time_pixel_tb;

    import jset_pkg::*;

    localparam int FRAC_BITS   = FRAC_BITS_DEFAULT;
    localparam int STALL_LIMIT = 100000;
    localparam int TAIL_CYCLES = 300;
    // |z|^2 >= 4 in the product scale of 2*FRAC_BITS fraction bits.
    localparam longint unsigned ESCAPE_BOUND = 64'd1 << (2 * FRAC_BITS + 2);

    typedef struct {
        logic [COLOUR_W-1:0] colour;
        logic [COUNT_W-1:0]  count;
        logic                in_set;
    } pixel_result_t;

    class escape_scoreboard;
        logic [DEN_W-1:0]   width_reg;
        logic [DEN_W-1:0]   height_reg;
        int                 c_re;
        int                 c_im;
        logic [COUNT_W-1:0] iter_limit;
        pixel_result_t      expected_q[$];
        int                 failures;

        function new();
            width_reg  = RESET_IMAGE_WIDTH;
            height_reg = RESET_IMAGE_HEIGHT;
            c_re       = int'(RESET_C_REAL);
            c_im       = int'(RESET_C_IMAG);
            iter_limit = RESET_MAX_ITER;
            failures   = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
            case (idx)
                CFG_IMAGE_WIDTH:  width_reg  = value[DEN_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg = value[DEN_W-1:0];
                CFG_C_REAL:       c_re       = int'(value);
                CFG_C_IMAG:       c_im       = int'(value);
                CFG_MAX_ITER:     iter_limit = value[COUNT_W-1:0];
                default:          ;
            endcase
        endfunction

        // floor(num * 2^FRAC_BITS / den), done as a long division.
        function longint unsigned scaled_quotient(longint unsigned num, longint unsigned den);
            longint unsigned q;
            longint unsigned r;
            q = num / den;
            r = num % den;
            for (int k = 0; k < FRAC_BITS; k++)
            begin
                q = q << 1;
                r = r << 1;
                if (r >= den)
                begin
                    r = r - den;
                    q = q | 64'd1;
                end
            end
            return q;
        endfunction

        function pixel_result_t escape_time(logic [PIXEL_W-1:0] px, logic [PIXEL_W-1:0] py);
            longint unsigned w;
            longint unsigned h;
            longint unsigned mag;
            longint          xx;
            longint          yy;
            longint          xy;
            int              zx;
            int              zy;
            int              nx;
            int unsigned     n;
            pixel_result_t   r;
            w  = (width_reg == 0) ? 64'd1 : 64'(width_reg);
            h  = (height_reg == 0) ? 64'd1 : 64'(height_reg);
            zx = int'(scaled_quotient(64'(px) * 64'd3, w) - (64'd3 << (FRAC_BITS - 1)));
            zy = int'(scaled_quotient(64'(py) * 64'd2, h) - (64'd1 << FRAC_BITS));
            n  = 0;
            while (n < iter_limit)
            begin
                xx  = longint'(zx) * longint'(zx);
                yy  = longint'(zy) * longint'(zy);
                xy  = longint'(zx) * longint'(zy);
                mag = $unsigned(xx) + $unsigned(yy);
                if (mag >= ESCAPE_BOUND)
                    break;
                nx = int'(((xx - yy) >>> FRAC_BITS) + longint'(c_re));
                zy = int'((xy >>> (FRAC_BITS - 1)) + longint'(c_im));
                zx = nx;
                n++;
            end
            r.count  = n[COUNT_W-1:0];
            r.in_set = (n == iter_limit);
            if (r.in_set)
                r.colour = '0;
            else
                r.colour = {8'd0, 8'((n * 255) / iter_limit), BLUE_LEVEL};
            return r;
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] px, logic [PIXEL_W-1:0] py);
            expected_q.push_back(escape_time(px, py));
        endfunction

        function void compare_field(string label, logic [COLOUR_W-1:0] want,
                                    logic [COLOUR_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] beat);
            pixel_result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result beat %h arrived with no pixel pending", $time, beat);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("colour", want.colour, beat[23:0]);
            compare_field("iteration_count", COLOUR_W'(want.count), COLOUR_W'(beat[35:24]));
            compare_field("inside_set", COLOUR_W'(want.in_set), COLOUR_W'(beat[36]));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [WORD_W-1:0]     cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    escape_scoreboard board = new();
    bit                steady_flow = 1'b0;
    int unsigned       quiet_cycles = 0;

    always #4 clk = ~clk;

    julia_set_escape_time_pixel dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Result side: check each accepted beat, then pick the next ready level.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
            m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_register(idx, value);
    endtask

    // Narrow registers get random bits above their width, which must be dropped.
    task automatic load_settings(input logic [DEN_W-1:0] w, input logic [DEN_W-1:0] h,
                                 input logic [WORD_W-1:0] cr, input logic [WORD_W-1:0] ci,
                                 input logic [COUNT_W-1:0] mi);
        write_register(CFG_IMAGE_WIDTH, {19'($urandom), w});
        write_register(CFG_IMAGE_HEIGHT, {19'($urandom), h});
        write_register(CFG_C_REAL, cr);
        write_register(CFG_C_IMAG, ci);
        write_register(CFG_MAX_ITER, {20'($urandom), mi});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic [PIXEL_W-1:0] py);
        while (!steady_flow && $urandom_range(0, 99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_pixel(px, py);
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int n_items, input int iter_lo, input int iter_hi);
        logic [DEN_W-1:0]   w;
        logic [DEN_W-1:0]   h;
        logic [WORD_W-1:0]  cr;
        logic [WORD_W-1:0]  ci;
        logic [PIXEL_W-1:0] px;
        logic [PIXEL_W-1:0] py;
        int                 span_x;
        int                 span_y;
        int                 pick;
        pick = $urandom_range(0, 9);
        w = (pick == 0) ? DEN_W'($urandom) : (pick == 1) ? 13'd1 : (pick == 2) ? 13'd4096
            : DEN_W'($urandom_range(2, 4096));
        pick = $urandom_range(0, 9);
        h = (pick == 0) ? DEN_W'($urandom) : (pick == 1) ? 13'd1 : (pick == 2) ? 13'd4096
            : DEN_W'($urandom_range(2, 4096));
        // Constants within +/-1.0 keep many points orbiting for a while.
        cr = ($urandom_range(0, 4) == 0) ? $urandom
            : 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
        ci = ($urandom_range(0, 4) == 0) ? $urandom
            : 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
        load_settings(w, h, cr, ci, COUNT_W'($urandom_range(iter_lo, iter_hi)));
        span_x = (w == 0) ? 1 : (w > 4096) ? 4096 : int'(w);
        span_y = (h == 0) ? 1 : (h > 4096) ? 4096 : int'(h);
        repeat (n_items)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                px = PIXEL_W'($urandom_range(0, span_x - 1));
                py = PIXEL_W'($urandom_range(0, span_y - 1));
            end
            else
            begin
                px = PIXEL_W'($urandom);
                py = PIXEL_W'($urandom);
            end
            send_pixel(px, py);
        end
        end_burst();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 640x480 frame, c = 0, limit 255.
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd320, 12'd240);
        send_pixel(12'd639, 12'd479);
        send_pixel(12'd0, 12'hFFF);
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'd160, 12'd120);
        send_pixel(12'd480, 12'd360);
        end_burst();

        // Zero frame size counts as one; zero limit does no iteration.
        write_register(CFG_IDX_W'(CFG_MAX_ITER + 1 + $urandom_range(0, 2)), $urandom);
        load_settings(13'd0, 13'd0, 32'h7FFF_FFFF, 32'h8000_0000, 12'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd5, 12'd3);
        end_burst();

        // Frame size above 4096 and the most extreme constants, limit of one.
        load_settings(13'h1FFF, 13'h1FFF, 32'h8000_0000, 32'h7FFF_FFFF, 12'd1);
        send_pixel(12'd0, 12'hFFF);
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'h555, 12'hAAA);
        end_burst();

        // Largest limit: the origin and -i never escape, 1.5 escapes after one step.
        load_settings(13'd2, 13'd2, 32'd0, 32'd0, 12'hFFF);
        send_pixel(12'd1, 12'd1);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd2, 12'd1);
        end_burst();

        load_settings(13'd1, 13'd4096, 32'hF333_3333, 32'h027E_FA00, 12'd64);
        send_pixel(12'd0, 12'd2048);
        send_pixel(12'd0, 12'd1000);
        send_pixel(12'd0, 12'd3000);
        end_burst();

        for (int p = 0; p < 18; p++)
        begin
            steady_flow = (p >= 4 && p < 7);
            if (p == 3)
                random_phase(100, 255, 255);
            else if (p == 9)
                random_phase(6, 4095, 4095);
            else if (p == 12)
                random_phase(100, 1, 1);
            else if (p == 15)
                random_phase(100, 0, 3);
            else
                random_phase(112, 1, 64);
        end
        steady_flow = 1'b0;

        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
